// ===== rtl/core/step_pulse_motion_monitor_assert.svh =====
// ---------------------------------------------------------------------------
// step pulse motion monitor assertion macros
// shared property shorthands for the checker
// ---------------------------------------------------------------------------
`ifndef STEP_PULSE_MOTION_MONITOR_ASSERT_SVH
`define STEP_PULSE_MOTION_MONITOR_ASSERT_SVH

// same-cycle implication
`define SPM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("step pulse monitor check failed");

// next-cycle implication
`define SPM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("step pulse monitor check failed");

`endif

// ===== rtl/core/spm_pkg.sv =====
// ---------------------------------------------------------------------------
// spm_pkg
// types, constants and helpers of the step pulse motion monitor
// ---------------------------------------------------------------------------
package spm_pkg;

  localparam int TIME_BITS     = 48;
  localparam int POS_BITS      = 32;
  localparam int CFG_BITS      = 63;
  localparam int LIMB_BITS     = 32;
  localparam int NUM_LIMBS     = 5;
  localparam int ACC_BITS      = LIMB_BITS * NUM_LIMBS;
  localparam int LIMB_CNT_BITS = $clog2(NUM_LIMBS);
  localparam int CFG_IDX_BITS  = 3;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_SLOW  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FAST  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LIMIT = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCALE = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PMIN  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PMAX  = 3'd5;

  // register reset values
  localparam logic [31:0]         SLOW_RST  = 32'd1000;
  localparam logic [31:0]         FAST_RST  = 32'd10;
  localparam logic [31:0]         LIMIT_RST = 32'd1000;
  localparam logic [CFG_BITS-1:0] SCALE_RST = 63'd2000000000000;
  localparam logic signed [31:0]  PMIN_RST  = -32'sd32768;
  localparam logic signed [31:0]  PMAX_RST  = 32'sd32767;

  // fault codes, y axis is the x code plus one
  localparam logic [3:0] FAULT_NONE   = 4'd0;
  localparam logic [3:0] FAULT_ZERO_X = 4'd1;
  localparam logic [3:0] FAULT_REV_X  = 4'd3;
  localparam logic [3:0] FAULT_SPD_X  = 4'd5;
  localparam logic [3:0] FAULT_ACC_X  = 4'd7;

  localparam logic signed [33:0] POS_LO = -(34'sd1 <<< (POS_BITS - 1));
  localparam logic signed [33:0] POS_HI = (34'sd1 <<< (POS_BITS - 1)) - 34'sd1;

  typedef struct packed {
    logic [TIME_BITS-1:0] timestamp;
    logic                 pulse_x;
    logic                 pulse_y;
    logic                 dir_x;
    logic                 dir_y;
    logic                 pen_down;
  } in_t;

  typedef struct packed {
    logic                 accepted;
    logic signed [31:0]   pos_x;
    logic signed [31:0]   pos_y;
    logic signed [31:0]   raw_x;
    logic signed [31:0]   raw_y;
    logic [3:0]           fault_code;
    logic [TIME_BITS-1:0] fault_time;
    logic                 pen_state;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EVAL,
    ST_LOAD_L,
    ST_MUL_L,
    ST_LOAD_R,
    ST_MUL_T0,
    ST_MUL_T1,
    ST_MUL_LIM,
    ST_UPDATE,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    OP_DIFF,
    OP_T0,
    OP_T1,
    OP_LIMIT
  } mul_op_e;

  typedef struct packed {
    logic    capture;
    logic    check;
    logic    eval;
    logic    load_scale;
    logic    load_sum;
    logic    save_lhs;
    logic    mul_step;
    mul_op_e mul_op;
    logic    update;
    logic    axis;
    logic    finish;
  } ctrl_t;

  typedef struct packed {
    logic accept_ok;
    logic pulse_x;
    logic pulse_y;
    logic zero_fault;
    logic accel_en;
    logic limb_last;
  } stat_t;

  // one step, then clamp to min, then max, then to the position range
  function automatic logic signed [31:0] clamp_step(input logic signed [31:0] p,
                                                    input logic               up,
                                                    input logic signed [31:0] lo,
                                                    input logic signed [31:0] hi);
    logic signed [33:0] v;
    v = $signed({{2{p[31]}}, p}) + (up ? 34'sd1 : -34'sd1);
    if (v < $signed({{2{lo[31]}}, lo})) v = $signed({{2{lo[31]}}, lo});
    if (v > $signed({{2{hi[31]}}, hi})) v = $signed({{2{hi[31]}}, hi});
    if (v < POS_LO) v = POS_LO;
    if (v > POS_HI) v = POS_HI;
    return v[31:0];
  endfunction

endpackage

// ===== rtl/core/step_pulse_motion_monitor.sv =====
// an item is taken only in the idle state and goes through the check state; each pulsed
//   axis adds the evaluation state and, on a nonzero interval, the update state, with
//   four passes of a shared 32x32 multiplier over five limbs before it for the
//   acceleration test; a new item is taken only once the last has left the output
//   state, and a result not taken yet holds the next one back in the output state
// reset: asynchronous, active low; monitor state, faults and registers return to defaults
// ---------------------------------------------------------------------------
// step_pulse_motion_monitor
// two axis step/direction pulse monitor with fault latching and position clamp
// ---------------------------------------------------------------------------
module step_pulse_motion_monitor import spm_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // item input
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  in_t                     in_data_i,
  // result output
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output out_t                    out_data_o,
  // register writes
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [CFG_BITS-1:0]     cfg_data_i
);

  // command and status between sequencer and datapath
  ctrl_t ctrl;
  stat_t stat;

  // sequencer: takes one transfer in idle, walks the axes, parks in the
  // output state until the result register is free
  spm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  // datapath: register file, axis state, checks, limb multiplier, result register
  spm_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .ctrl_i     (ctrl),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

endmodule

// ===== rtl/core/spm_ctrl.sv =====
// ---------------------------------------------------------------------------
// spm_ctrl
// sequencer of the monitor: item check, per axis evaluation, multiply passes
// ---------------------------------------------------------------------------
module spm_ctrl import spm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  state_e state_q, state_d;
  logic   axis_q, axis_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (!stat_i.accept_ok) begin
          state_d = ST_OUT;
        end else if (stat_i.pulse_x) begin
          axis_d  = 1'b0;
          state_d = ST_EVAL;
        end else if (stat_i.pulse_y) begin
          axis_d  = 1'b1;
          state_d = ST_EVAL;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_EVAL: begin
        if (stat_i.zero_fault) begin
          if (!axis_q && stat_i.pulse_y) begin
            axis_d  = 1'b1;
            state_d = ST_EVAL;
          end else begin
            state_d = ST_OUT;
          end
        end else if (stat_i.accel_en) begin
          state_d = ST_LOAD_L;
        end else begin
          state_d = ST_UPDATE;
        end
      end
      ST_LOAD_L:  state_d = ST_MUL_L;
      ST_MUL_L: begin
        if (stat_i.limb_last) state_d = ST_LOAD_R;
      end
      ST_LOAD_R:  state_d = ST_MUL_T0;
      ST_MUL_T0: begin
        if (stat_i.limb_last) state_d = ST_MUL_T1;
      end
      ST_MUL_T1: begin
        if (stat_i.limb_last) state_d = ST_MUL_LIM;
      end
      ST_MUL_LIM: begin
        if (stat_i.limb_last) state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (!axis_q && stat_i.pulse_y) begin
          axis_d  = 1'b1;
          state_d = ST_EVAL;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl_o      = '0;
    ctrl_o.axis = axis_q;
    case (state_q)
      ST_IDLE:    ctrl_o.capture = in_valid_i;
      ST_CHECK:   ctrl_o.check = 1'b1;
      ST_EVAL:    ctrl_o.eval = 1'b1;
      ST_LOAD_L:  ctrl_o.load_scale = 1'b1;
      ST_MUL_L: begin
        ctrl_o.mul_step = 1'b1;
        ctrl_o.mul_op   = OP_DIFF;
      end
      ST_LOAD_R: begin
        ctrl_o.save_lhs = 1'b1;
        ctrl_o.load_sum = 1'b1;
      end
      ST_MUL_T0: begin
        ctrl_o.mul_step = 1'b1;
        ctrl_o.mul_op   = OP_T0;
      end
      ST_MUL_T1: begin
        ctrl_o.mul_step = 1'b1;
        ctrl_o.mul_op   = OP_T1;
      end
      ST_MUL_LIM: begin
        ctrl_o.mul_step = 1'b1;
        ctrl_o.mul_op   = OP_LIMIT;
      end
      ST_UPDATE:  ctrl_o.update = 1'b1;
      ST_OUT:     ctrl_o.finish = !out_valid_q || out_ready_i;
      default:    ctrl_o.finish = 1'b0;
    endcase
  end

  always_comb begin
    if (ctrl_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/spm_datapath.sv =====
// ---------------------------------------------------------------------------
// spm_datapath
// config registers, axis state, interval checks and limb serial multiplier
// ---------------------------------------------------------------------------
module spm_datapath import spm_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  in_t                     in_data_i,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [CFG_BITS-1:0]     cfg_data_i,
  input  ctrl_t                   ctrl_i,
  output stat_t                   stat_o,
  output out_t                    out_data_o
);

  // configuration
  logic [31:0]         slow_q, fast_q, limit_q;
  logic [CFG_BITS-1:0] scale_q;
  logic signed [31:0]  pmin_q, pmax_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slow_q  <= SLOW_RST;
      fast_q  <= FAST_RST;
      limit_q <= LIMIT_RST;
      scale_q <= SCALE_RST;
      pmin_q  <= PMIN_RST;
      pmax_q  <= PMAX_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SLOW:  slow_q  <= cfg_data_i[31:0];
        CFG_FAST:  fast_q  <= cfg_data_i[31:0];
        CFG_LIMIT: limit_q <= cfg_data_i[31:0];
        CFG_SCALE: scale_q <= cfg_data_i;
        CFG_PMIN:  pmin_q  <= $signed(cfg_data_i[31:0]);
        CFG_PMAX:  pmax_q  <= $signed(cfg_data_i[31:0]);
        default:   slow_q  <= slow_q;
      endcase
    end
  end

  // captured item
  in_t in_q;
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) in_q <= in_data_i;
  end

  // monitor state
  logic [TIME_BITS-1:0] last_time_q;
  logic signed [31:0]   pos_q [2];
  logic signed [31:0]   raw_q [2];
  logic [TIME_BITS-1:0] prev_time_q [2];
  logic [TIME_BITS-1:0] older_time_q [2];
  logic [1:0]           pv_q, ov_q, pdir_q, killed_q;
  logic [3:0]           fault_q;
  logic [TIME_BITS-1:0] fault_time_q;
  logic                 pen_q, item_ok_q;

  // per axis evaluation
  logic                 ax, dir, pv, ov;
  logic [TIME_BITS-1:0] pt, ot, t0, t1, slow_w, fast_w;
  logic                 zero_f, rev_f, spd_f, acc_en, unlock;

  assign ax     = ctrl_i.axis;
  assign dir    = ax ? in_q.dir_y : in_q.dir_x;
  assign pv     = pv_q[ax];
  assign ov     = ov_q[ax];
  assign pt     = prev_time_q[ax];
  assign ot     = older_time_q[ax];
  assign slow_w = TIME_BITS'(slow_q);
  assign fast_w = TIME_BITS'(fast_q);
  assign t0     = (pv && in_q.timestamp >= pt) ? in_q.timestamp - pt : '0;
  assign t1     = (ov && pt >= ot) ? pt - ot : '0;
  assign unlock = !pv || t0 >= slow_w;
  assign zero_f = pv && (t0 == '0);
  assign rev_f  = ov && (t0 < slow_w || t1 < slow_w) && (dir != pdir_q[ax]);
  assign spd_f  = pv && (t0 < fast_w);
  assign acc_en = ov && (t0 <= slow_w) && (t1 <= slow_w);

  // limb serial multiplier: acc rotates one limb per step
  logic [31:0]              t0_q, t1_q;
  logic                     acc_en_q;
  logic [ACC_BITS-1:0]      acc_q, lhs_q;
  logic [31:0]              carry_q, mul_m, diff;
  logic [LIMB_CNT_BITS-1:0] cnt_q;
  logic [63:0]              prod;
  logic                     limb_last;

  assign diff      = (t1_q > t0_q) ? t1_q - t0_q : t0_q - t1_q;
  assign limb_last = (cnt_q == LIMB_CNT_BITS'(NUM_LIMBS - 1));

  always_comb begin
    case (ctrl_i.mul_op)
      OP_DIFF:  mul_m = diff;
      OP_T0:    mul_m = t0_q;
      OP_T1:    mul_m = t1_q;
      OP_LIMIT: mul_m = limit_q;
      default:  mul_m = '0;
    endcase
  end

  assign prod = 64'(acc_q[LIMB_BITS-1:0]) * 64'(mul_m)
              + 64'((cnt_q == '0) ? 32'd0 : carry_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctrl_i.mul_step) begin
      cnt_q <= limb_last ? '0 : cnt_q + LIMB_CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.eval) begin
      t0_q     <= t0[31:0];
      t1_q     <= t1[31:0];
      acc_en_q <= acc_en && !zero_f;
    end
    if (ctrl_i.save_lhs) lhs_q <= acc_q;
    if (ctrl_i.load_scale) begin
      acc_q <= ACC_BITS'(scale_q);
    end else if (ctrl_i.load_sum) begin
      acc_q <= ACC_BITS'({1'b0, t0_q} + {1'b0, t1_q});
    end else if (ctrl_i.mul_step) begin
      acc_q   <= {prod[LIMB_BITS-1:0], acc_q[ACC_BITS-1:LIMB_BITS]};
      carry_q <= prod[63:32];
    end
  end

  logic accel_hit, killed_now;
  assign accel_hit  = acc_en_q && (lhs_q >= acc_q);
  assign killed_now = killed_q[ax] || accel_hit;

  logic accept_ok;
  assign accept_ok = !(in_q.timestamp < last_time_q ||
                       (in_q.timestamp == last_time_q && !in_q.pulse_x && !in_q.pulse_y));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_time_q  <= '0;
      pos_q[0]     <= '0;
      pos_q[1]     <= '0;
      raw_q[0]     <= '0;
      raw_q[1]     <= '0;
      prev_time_q[0]  <= '0;
      prev_time_q[1]  <= '0;
      older_time_q[0] <= '0;
      older_time_q[1] <= '0;
      pv_q         <= '0;
      ov_q         <= '0;
      pdir_q       <= '0;
      killed_q     <= '0;
      fault_q      <= FAULT_NONE;
      fault_time_q <= '0;
      pen_q        <= 1'b0;
      item_ok_q    <= 1'b0;
    end else begin
      if (ctrl_i.check) begin
        item_ok_q <= accept_ok;
        if (accept_ok) begin
          last_time_q <= in_q.timestamp;
          pen_q       <= in_q.pen_down;
        end
      end
      if (ctrl_i.eval) begin
        if (zero_f) begin
          killed_q[ax] <= 1'b1;
          if (fault_q == FAULT_NONE) begin
            fault_q      <= FAULT_ZERO_X + 4'(ax);
            fault_time_q <= in_q.timestamp;
          end
        end else begin
          if (rev_f) killed_q[ax] <= 1'b1;
          else if (unlock) killed_q[ax] <= 1'b0;
          if (fault_q == FAULT_NONE && (rev_f || spd_f)) begin
            fault_q      <= (rev_f ? FAULT_REV_X : FAULT_SPD_X) + 4'(ax);
            fault_time_q <= in_q.timestamp;
          end
        end
      end
      if (ctrl_i.update) begin
        if (accel_hit) begin
          killed_q[ax] <= 1'b1;
          if (fault_q == FAULT_NONE) begin
            fault_q      <= FAULT_ACC_X + 4'(ax);
            fault_time_q <= in_q.timestamp;
          end
        end
        if (!killed_now) pos_q[ax] <= clamp_step(pos_q[ax], dir, pmin_q, pmax_q);
        raw_q[ax]        <= clamp_step(raw_q[ax], dir, pmin_q, pmax_q);
        older_time_q[ax] <= pt;
        ov_q[ax]         <= pv;
        prev_time_q[ax]  <= in_q.timestamp;
        pv_q[ax]         <= 1'b1;
        pdir_q[ax]       <= dir;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.finish) begin
      out_data_o.accepted   <= item_ok_q;
      out_data_o.pos_x      <= pos_q[0];
      out_data_o.pos_y      <= pos_q[1];
      out_data_o.raw_x      <= raw_q[0];
      out_data_o.raw_y      <= raw_q[1];
      out_data_o.fault_code <= fault_q;
      out_data_o.fault_time <= fault_time_q;
      out_data_o.pen_state  <= pen_q;
    end
  end

  assign stat_o.accept_ok  = accept_ok;
  assign stat_o.pulse_x    = in_q.pulse_x;
  assign stat_o.pulse_y    = in_q.pulse_y;
  assign stat_o.zero_fault = zero_f;
  assign stat_o.accel_en   = acc_en;
  assign stat_o.limb_last  = limb_last;

endmodule

// ===== rtl/core/spm_checker.sv =====
// ---------------------------------------------------------------------------
// spm_checker
// port level checks of the step pulse motion monitor
// ---------------------------------------------------------------------------
`include "step_pulse_motion_monitor_assert.svh"

module spm_checker import spm_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  // a stalled result holds
  `SPM_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

  // one item in flight: ready drops after an input transfer
  `SPM_ASSERT_NEXT(a_one_item, in_valid_i && in_ready_o, !in_ready_o)

  // fault code stays in its range
  `SPM_ASSERT_NOW(a_code_range, out_valid_o, out_data_o.fault_code <= 4'd8)

  // no fault means no fault time
  `SPM_ASSERT_NOW(a_no_fault_time, out_valid_o && out_data_o.fault_code == FAULT_NONE,
                  out_data_o.fault_time == '0)

endmodule

bind step_pulse_motion_monitor spm_checker u_spm_checker (.*);

// ===== tb/tb_step_pulse_motion_monitor.sv =====
// ---------------------------------------------------------------------------
// tb_step_pulse_motion_monitor
// self-checking bench: pulse trains with random gaps on both handshakes, an
// in-bench model of the axis checks and clamps, results compared per field
// ---------------------------------------------------------------------------
module tb_step_pulse_motion_monitor;
  import spm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  // tracks monitor state and the first latched fault, holds expected results
  class motion_scoreboard;
    logic [31:0]          slow_iv, fast_iv, acc_limit;
    logic [CFG_BITS-1:0]  acc_scale;
    logic signed [31:0]   pos_min, pos_max;
    logic [TIME_BITS-1:0] last_t, fault_t;
    logic [TIME_BITS-1:0] prev_t [2], older_t [2];
    logic                 prev_ok [2], older_ok [2], prev_dir [2], killed [2];
    logic signed [31:0]   pos [2], raw [2];
    logic [3:0]           fault;
    logic                 pen;
    out_t                 expected_q [$];
    int                   errors;

    function new();
      slow_iv   = SLOW_RST;
      fast_iv   = FAST_RST;
      acc_limit = LIMIT_RST;
      acc_scale = SCALE_RST;
      pos_min   = PMIN_RST;
      pos_max   = PMAX_RST;
      last_t    = '0;
      fault_t   = '0;
      fault     = FAULT_NONE;
      pen       = 1'b0;
      errors    = 0;
      for (int i = 0; i < 2; i++) begin
        prev_t[i]   = '0;
        older_t[i]  = '0;
        prev_ok[i]  = 1'b0;
        older_ok[i] = 1'b0;
        prev_dir[i] = 1'b0;
        killed[i]   = 1'b0;
        pos[i]      = '0;
        raw[i]      = '0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] v);
      case (idx)
        CFG_SLOW:  slow_iv   = v[31:0];
        CFG_FAST:  fast_iv   = v[31:0];
        CFG_LIMIT: acc_limit = v[31:0];
        CFG_SCALE: acc_scale = v;
        CFG_PMIN:  pos_min   = v[31:0];
        CFG_PMAX:  pos_max   = v[31:0];
        default: ;
      endcase
    endfunction

    // min first, then max, so max wins when the bounds cross
    function logic signed [31:0] bounded_step(logic signed [31:0] p, logic up);
      logic signed [33:0] v;
      v = 34'(p) + (up ? 34'sd1 : -34'sd1);
      if (v < 34'(pos_min)) v = 34'(pos_min);
      if (v > 34'(pos_max)) v = 34'(pos_max);
      if (v < -34'sd2147483648) v = -34'sd2147483648;
      if (v > 34'sd2147483647) v = 34'sd2147483647;
      return v[31:0];
    endfunction

    function void latch_fault(logic [3:0] code, logic [TIME_BITS-1:0] t);
      if (fault == FAULT_NONE) begin
        fault   = code;
        fault_t = t;
      end
    endfunction

    function void axis_pulse(int i, logic [TIME_BITS-1:0] t, logic dir);
      logic [TIME_BITS-1:0] t0, t1, diff;
      logic [255:0]         lhs, rhs, f0, f1, f2;
      logic                 pv, ov;
      pv = prev_ok[i];
      ov = older_ok[i];
      t0 = (pv && t >= prev_t[i]) ? t - prev_t[i] : '0;
      t1 = (ov && prev_t[i] >= older_t[i]) ? prev_t[i] - older_t[i] : '0;
      if (!pv || t0 >= slow_iv) killed[i] = 1'b0;
      // zero interval drops the pulse entirely
      if (pv && t0 == 0) begin
        latch_fault(FAULT_ZERO_X + 4'(i), t);
        killed[i] = 1'b1;
        return;
      end
      // reversal while still moving fast
      if (ov && (t0 < slow_iv || t1 < slow_iv) && dir != prev_dir[i]) begin
        latch_fault(FAULT_REV_X + 4'(i), t);
        killed[i] = 1'b1;
      end
      if (pv && t0 < fast_iv) latch_fault(FAULT_SPD_X + 4'(i), t);
      // exact acceleration test on wide products
      if (ov && t0 <= slow_iv && t1 <= slow_iv) begin
        diff = (t1 > t0) ? t1 - t0 : t0 - t1;
        lhs  = 256'(acc_scale);
        f0   = 256'(diff[31:0]);
        lhs  = lhs * f0;
        rhs  = 256'(64'(t0) + 64'(t1));
        f0   = 256'(t0[31:0]);
        f1   = 256'(t1[31:0]);
        f2   = 256'(acc_limit);
        rhs  = rhs * f0 * f1 * f2;
        if (lhs >= rhs) begin
          killed[i] = 1'b1;
          latch_fault(FAULT_ACC_X + 4'(i), t);
        end
      end
      if (!killed[i]) pos[i] = bounded_step(pos[i], dir);
      raw[i]      = bounded_step(raw[i], dir);
      older_t[i]  = prev_t[i];
      older_ok[i] = pv;
      prev_t[i]   = t;
      prev_ok[i]  = 1'b1;
      prev_dir[i] = dir;
    endfunction

    function void note_input(in_t it);
      out_t r;
      logic take;
      take = !(it.timestamp < last_t ||
               (it.timestamp == last_t && !it.pulse_x && !it.pulse_y));
      if (take) begin
        last_t = it.timestamp;
        if (it.pulse_x) axis_pulse(0, it.timestamp, it.dir_x);
        if (it.pulse_y) axis_pulse(1, it.timestamp, it.dir_y);
        pen = it.pen_down;
      end
      r.accepted   = take;
      r.pos_x      = pos[0];
      r.pos_y      = pos[1];
      r.raw_x      = raw[0];
      r.raw_y      = raw[1];
      r.fault_code = fault;
      r.fault_time = fault_t;
      r.pen_state  = pen;
      expected_q.push_back(r);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
      errors++;
    endtask

    task check_result(out_t got);
      out_t w;
      if (expected_q.size() == 0) begin
        report("unexpected result", 64'(got.accepted), 64'd0);
        return;
      end
      w = expected_q.pop_front();
      if (got.accepted !== w.accepted)     report("accepted", 64'(got.accepted), 64'(w.accepted));
      if (got.pos_x !== w.pos_x)           report("pos_x", 64'(got.pos_x), 64'(w.pos_x));
      if (got.pos_y !== w.pos_y)           report("pos_y", 64'(got.pos_y), 64'(w.pos_y));
      if (got.raw_x !== w.raw_x)           report("raw_x", 64'(got.raw_x), 64'(w.raw_x));
      if (got.raw_y !== w.raw_y)           report("raw_y", 64'(got.raw_y), 64'(w.raw_y));
      if (got.fault_code !== w.fault_code) report("fault_code", 64'(got.fault_code),
                                                  64'(w.fault_code));
      if (got.fault_time !== w.fault_time) report("fault_time", 64'(got.fault_time),
                                                  64'(w.fault_time));
      if (got.pen_state !== w.pen_state)   report("pen_state", 64'(got.pen_state),
                                                  64'(w.pen_state));
    endtask
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  in_t                     in_data = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  out_t                    out_data;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx = CFG_SLOW;
  logic [CFG_BITS-1:0]     cfg_data = '0;

  motion_scoreboard        sb = new();
  logic [TIME_BITS-1:0]    now_t = '0;  // stimulus time base
  logic                    dir_now [2] = '{1'b1, 1'b1};
  bit                      send_gaps = 1'b1;
  bit                      recv_gaps = 1'b1;

  step_pulse_motion_monitor dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // one transfer per call; valid stays high when the next item follows directly
  task automatic send_item(in_t it);
    int gap;
    gap = send_gaps ? $urandom_range(18) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk_i); while (!in_ready);
    sb.note_input(it);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] v);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= v;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    sb.write_reg(idx, v);
  endtask

  // block must be idle: every item gives a result, so an empty queue is enough
  task automatic set_config(logic [31:0] slow, logic [31:0] fast, logic [31:0] lim,
                            logic [CFG_BITS-1:0] scale, logic [31:0] pmin,
                            logic [31:0] pmax);
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    write_reg(CFG_SLOW, 63'(slow));
    write_reg(CFG_FAST, 63'(fast));
    write_reg(CFG_LIMIT, 63'(lim));
    write_reg(CFG_SCALE, scale);
    write_reg(CFG_PMIN, 63'(pmin));
    write_reg(CFG_PMAX, 63'(pmax));
  endtask

  // interval drawn around the speed bounds so that every check gets exercised
  function automatic logic [63:0] pick_interval();
    int r;
    r = $urandom_range(99);
    if (r < 5)  return 64'd0;
    if (r < 22) return 64'($urandom_range(sb.fast_iv));
    if (r < 60) return 64'($urandom_range(sb.slow_iv));
    if (r < 78) return 64'(sb.slow_iv) + 64'($urandom_range(2)) - 64'd1;
    return 64'(sb.slow_iv) + 64'($urandom_range(5000));
  endfunction

  task automatic send_random();
    in_t         it;
    logic [63:0] nxt;
    int          r;
    r = $urandom_range(99);
    it.pen_down = 1'($urandom_range(1));
    it.pulse_x  = ($urandom_range(99) < 70);
    it.pulse_y  = ($urandom_range(99) < 70);
    for (int i = 0; i < 2; i++)
      if ($urandom_range(99) < 12) dir_now[i] = ~dir_now[i];
    it.dir_x = ($urandom_range(99) < 5) ? 1'($urandom_range(1)) : dir_now[0];
    it.dir_y = ($urandom_range(99) < 5) ? 1'($urandom_range(1)) : dir_now[1];
    if (r < 8) begin
      // noise: a stale time, or a repeat with no pulse
      it.timestamp = (r < 4) ? TIME_BITS'({$urandom, $urandom} % (64'(now_t) + 64'd1))
                             : now_t;
      if (r >= 4) begin
        it.pulse_x = 1'b0;
        it.pulse_y = 1'b0;
      end
    end else begin
      nxt = 64'(now_t) + pick_interval();
      now_t = (nxt > 64'(TIME_MAX)) ? TIME_MAX : nxt[TIME_BITS-1:0];
      it.timestamp = now_t;
    end
    send_item(it);
  endtask

  task automatic send_at(logic [63:0] t, logic px, logic py, logic dx, logic dy, logic pd);
    in_t it;
    it.timestamp = t[TIME_BITS-1:0];
    it.pulse_x   = px;
    it.pulse_y   = py;
    it.dir_x     = dx;
    it.dir_y     = dy;
    it.pen_down  = pd;
    if (t[TIME_BITS-1:0] > now_t) now_t = t[TIME_BITS-1:0];
    send_item(it);
  endtask

  task automatic random_phase(int n);
    for (int k = 0; k < n; k++) begin
      // stretches with or without idling, chosen per side
      if (k % 40 == 0) begin
        send_gaps = ($urandom_range(3) != 0);
        recv_gaps = ($urandom_range(3) != 0);
      end
      send_random();
    end
  endtask

  // result side: random stall before each transfer
  initial begin
    int w;
    @(posedge rst_ni);
    forever begin
      w = recv_gaps ? $urandom_range(18) : 0;
      if (w > 0) begin
        out_ready <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
      sb.check_result(out_data);
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: defaults after reset
    send_at(0, 0, 0, 0, 0, 1);        // repeat of time zero without pulse: ignored
    send_at(0, 1, 0, 1, 0, 1);        // first x pulse, no history
    send_at(0, 1, 1, 1, 1, 0);        // zero interval on x, first y pulse
    send_at(5, 1, 1, 1, 0, 1);        // speeding on both
    send_at(505, 1, 1, 1, 0, 1);
    send_at(905, 1, 1, 0, 1, 0);      // reversal at high speed
    send_at(910, 1, 1, 0, 1, 1);
    send_at(2000, 1, 1, 0, 1, 1);     // slow interval unlocks
    send_at(3000, 1, 1, 1, 1, 0);     // exactly at the slow bound
    send_at(3999, 1, 1, 1, 1, 0);
    send_at(4600, 1, 0, 1, 1, 1);     // acceleration
    send_at(100, 1, 1, 1, 1, 1);      // time going backwards: ignored
    send_at(4600, 0, 0, 1, 1, 0);     // repeat without pulse: ignored
    send_at(4600, 0, 1, 1, 1, 0);     // repeat time with a y pulse only
    send_at(9000, 0, 0, 0, 0, 0);     // time advance without pulses
    random_phase(150);

    // narrow window, tuned so acceleration sometimes passes
    set_config(60, 8, 50000, 63'd2000000000, -32'sd4, 32'sd6);
    random_phase(130);

    // lowest bounds, crossed position limits, no acceleration margin
    set_config(1, 1, 0, 63'd1, 32'sd3, -32'sd3);
    random_phase(90);

    // highest bounds and full position range
    set_config('1, '1, '1, '1, 32'h8000_0000, 32'h7fff_ffff);
    random_phase(90);

    // positions pinned against the lowest value
    set_config(200, 20, $urandom, 63'({$urandom, $urandom}) >> $urandom_range(40),
               32'h8000_0000, 32'h8000_0001);
    random_phase(100);

    // random settings
    set_config($urandom_range(2000, 2), $urandom_range(40, 1), $urandom_range(100000),
               63'($urandom) * 63'($urandom_range(5000, 1)),
               -32'($urandom_range(20)), 32'($urandom_range(20)));
    random_phase(130);

    // top of the time range
    set_config(300, 15, 2000, 63'd5000000000, -32'sd10, 32'sd10);
    now_t = TIME_MAX - TIME_BITS'(60000);
    random_phase(60);
    send_at(64'(TIME_MAX), 1, 1, 1, 1, 1);

    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/spm_pkg.sv
rtl/core/spm_ctrl.sv
rtl/core/spm_datapath.sv
rtl/core/step_pulse_motion_monitor.sv
rtl/core/spm_checker.sv
tb/tb_step_pulse_motion_monitor.sv
